// ===== rtl/gbhl_pkg.sv =====
// Shared constants for the bilinear grid height lookup.
// Used by grid_bilinear_height_lookup; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbhl_pkg;

  localparam int MAX_ROWS_DEF      = 256;
  localparam int MAX_COLUMNS_DEF   = 256;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int COORD_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 9;
  localparam int CFG_IX_W = 3;
  localparam int OUT_W    = 32;

  // Config register indexes
  localparam logic [CFG_IX_W-1:0] REG_ROW_COUNT        = 3'd0;
  localparam logic [CFG_IX_W-1:0] REG_COLUMN_COUNT     = 3'd1;
  localparam logic [CFG_IX_W-1:0] REG_LEFT_EDGE        = 3'd2;
  localparam logic [CFG_IX_W-1:0] REG_BOTTOM_EDGE      = 3'd3;
  localparam logic [CFG_IX_W-1:0] REG_CELLS_PER_DEGREE = 3'd4;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [COUNT_W-1:0] RST_COUNT = 9'd1;
  localparam logic [31:0]        RST_CPD   = 32'h0001_0000;

endpackage

`default_nettype wire

// ===== rtl/gbhl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gbhl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grid_bilinear_height_lookup.sv =====
// Bilinear height lookup over a stored elevation grid: top level.
// Depends on gbhl_pkg and gbhl_ram.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one beat per cycle, writes and queries alike, when no
// stage is stalled by output backpressure. A query yields one height; a
// write yields none and stores its sample when it reaches the memory
// stage, so queries and writes act in arrival order. The grid is held in
// four identical RAM copies that every in-range write updates, giving the
// four neighbour reads at once. Grid contents are undefined until written;
// there is no clearing pass after reset. Each pipeline stage only stalls
// when the stage after it is full, so bubbles are squeezed out under
// output backpressure. Config writes are taken at any time (cfg_ready is
// always high) and must only be issued while the pipeline is empty.
module grid_bilinear_height_lookup #(
  parameter int MAX_ROWS      = gbhl_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS   = gbhl_pkg::MAX_COLUMNS_DEF,
  parameter int FRACTION_BITS = gbhl_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                mode,
  input  wire logic        [15:0]                  cell_index,
  input  wire logic signed [gbhl_pkg::SAMPLE_W-1:0] cell_value,
  input  wire logic signed [gbhl_pkg::COORD_W-1:0] longitude,
  input  wire logic signed [gbhl_pkg::COORD_W-1:0] latitude,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [gbhl_pkg::OUT_W-1:0]   height,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic        [gbhl_pkg::CFG_IX_W-1:0] cfg_index,
  input  wire logic        [31:0]                  cfg_data
);

  localparam int F    = FRACTION_BITS;
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int GRID = MAX_ROWS * MAX_COLUMNS;
  localparam int AW   = $clog2(GRID);
  localparam int PSH  = 38 - F;
  localparam int PW   = 65 - PSH;
  localparam int LW   = F + 18;
  localparam int DW   = LW + 1;
  localparam int MW   = DW + F + 1;
  localparam int OSH  = 2 * F - 16;
  localparam int NST  = 14;
  localparam int SW   = gbhl_pkg::SAMPLE_W;

  // ---------------- configuration ----------------
  logic [gbhl_pkg::COUNT_W-1:0] row_count;
  logic [gbhl_pkg::COUNT_W-1:0] column_count;
  logic [31:0]                  left_edge;
  logic [31:0]                  bottom_edge;
  logic [31:0]                  cells_per_degree;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count        <= gbhl_pkg::RST_COUNT;
      column_count     <= gbhl_pkg::RST_COUNT;
      left_edge        <= '0;
      bottom_edge      <= '0;
      cells_per_degree <= gbhl_pkg::RST_CPD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gbhl_pkg::REG_ROW_COUNT:        row_count        <= cfg_data[gbhl_pkg::COUNT_W-1:0];
        gbhl_pkg::REG_COLUMN_COUNT:     column_count     <= cfg_data[gbhl_pkg::COUNT_W-1:0];
        gbhl_pkg::REG_LEFT_EDGE:        left_edge        <= cfg_data;
        gbhl_pkg::REG_BOTTOM_EDGE:      bottom_edge      <= cfg_data;
        gbhl_pkg::REG_CELLS_PER_DEGREE: cells_per_degree <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective counts, clamped to 1..MAX
  logic [31:0]   rows32, cols32;
  logic [RW-1:0] rows_m1;
  logic [CW-1:0] cols_m1;
  logic [CW:0]   cols_n;

  always_comb begin
    if (row_count == '0) begin
      rows32 = 32'd1;
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      rows32 = 32'(MAX_ROWS);
    end else begin
      rows32 = 32'(row_count);
    end
    if (column_count == '0) begin
      cols32 = 32'd1;
    end else if (32'(column_count) > 32'(MAX_COLUMNS)) begin
      cols32 = 32'(MAX_COLUMNS);
    end else begin
      cols32 = 32'(column_count);
    end
  end

  assign rows_m1 = RW'(rows32 - 32'd1);
  assign cols_m1 = CW'(cols32 - 32'd1);
  assign cols_n  = (CW+1)'(cols32);

  // ---------------- pipeline flow control ----------------
  logic [NST:1] v;
  logic [NST:1] en;

  always_comb begin
    en[NST] = !v[NST] || out_ready;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[NST];

  // ---------------- stage 1: offset from origin ----------------
  logic               mode1;
  logic [15:0]        widx1;
  logic [SW-1:0]      wval1;
  logic signed [32:0] dc1, dl1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mode1 <= mode;
      widx1 <= cell_index;
      wval1 <= cell_value;
      dc1   <= $signed({longitude[31], longitude}) - $signed({left_edge[31], left_edge});
      dl1   <= $signed({latitude[31], latitude}) - $signed({bottom_edge[31], bottom_edge});
    end
  end

  // ---------------- stage 2: magnitude ----------------
  logic          mode2;
  logic [15:0]   widx2;
  logic [SW-1:0] wval2;
  logic [32:0]   mc2, ml2;
  logic          nc2, nl2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mode2 <= mode1;
      widx2 <= widx1;
      wval2 <= wval1;
      nc2   <= dc1[32];
      nl2   <= dl1[32];
      mc2   <= dc1[32] ? (~dc1 + 33'd1) : dc1;
      ml2   <= dl1[32] ? (~dl1 + 33'd1) : dl1;
    end
  end

  // ---------------- stage 3: partial products ----------------
  logic          mode3;
  logic [15:0]   widx3;
  logic [SW-1:0] wval3;
  logic [48:0]   pcl3, pch3, pll3, plh3;
  logic          nc3, nl3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mode3 <= mode2;
      widx3 <= widx2;
      wval3 <= wval2;
      nc3   <= nc2;
      nl3   <= nl2;
      pcl3  <= 49'(mc2) * 49'(cells_per_degree[15:0]);
      pch3  <= 49'(mc2) * 49'(cells_per_degree[31:16]);
      pll3  <= 49'(ml2) * 49'(cells_per_degree[15:0]);
      plh3  <= 49'(ml2) * 49'(cells_per_degree[31:16]);
    end
  end

  // ---------------- stage 4: grid position ----------------
  logic          mode4;
  logic [15:0]   widx4;
  logic [SW-1:0] wval4;
  logic [PW-1:0] cpos4, lpos4;
  logic          cbel4, lbel4;
  logic [64:0]   prod_c, prod_l;

  assign prod_c = 65'(pcl3) + (65'(pch3) << 16);
  assign prod_l = 65'(pll3) + (65'(plh3) << 16);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mode4 <= mode3;
      widx4 <= widx3;
      wval4 <= wval3;
      // negative offset gives a nonzero product unless the scale is zero
      cbel4 <= nc3 && (cells_per_degree != '0);
      lbel4 <= nl3 && (cells_per_degree != '0);
      cpos4 <= nc3 ? '0 : prod_c[64:PSH];
      lpos4 <= nl3 ? '0 : prod_l[64:PSH];
    end
  end

  // ---------------- stage 5: clamp and row flip ----------------
  logic             mode5;
  logic [15:0]      widx5;
  logic [SW-1:0]    wval5;
  logic [CW+F-1:0]  cpos5, ctop;
  logic [RW+F-1:0]  rpos5, rtop;
  logic             cbl5, rbl5;

  assign ctop = {cols_m1, {F{1'b0}}};
  assign rtop = {rows_m1, {F{1'b0}}};

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mode5 <= mode4;
      widx5 <= widx4;
      wval5 <= wval4;
      if (cbel4) begin
        cpos5 <= '0;
        cbl5  <= 1'b0;
      end else if (cpos4 > PW'(ctop)) begin
        cpos5 <= ctop;
        cbl5  <= 1'b0;
      end else begin
        cpos5 <= cpos4[CW+F-1:0];
        cbl5  <= 1'b1;
      end
      // south of the grid lands on the last row
      if (lbel4) begin
        rpos5 <= rtop;
        rbl5  <= 1'b0;
      end else if (lpos4 > PW'(rtop)) begin
        rpos5 <= '0;
        rbl5  <= 1'b0;
      end else begin
        rpos5 <= rtop - lpos4[RW+F-1:0];
        rbl5  <= 1'b1;
      end
    end
  end

  // ---------------- stage 6: indexes and weights ----------------
  logic          mode6;
  logic [15:0]   widx6;
  logic [SW-1:0] wval6;
  logic [CW-1:0] c0_6, c1_6;
  logic [RW-1:0] r0_6, r1_6;
  logic [F-1:0]  tc6, tr6;
  logic [CW-1:0] ci;
  logic [RW-1:0] ri;

  assign ci = cpos5[CW+F-1:F];
  assign ri = rpos5[RW+F-1:F];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mode6 <= mode5;
      widx6 <= widx5;
      wval6 <= wval5;
      c0_6  <= ci;
      r0_6  <= ri;
      // neighbour stays inside the grid on the last row or column
      c1_6  <= (cbl5 && ci != cols_m1) ? ci + CW'(1) : ci;
      r1_6  <= (rbl5 && ri != rows_m1) ? ri + RW'(1) : ri;
      tc6   <= cbl5 ? cpos5[F-1:0] : '0;
      tr6   <= rbl5 ? rpos5[F-1:0] : '0;
    end
  end

  // ---------------- stage 7: cell addresses ----------------
  logic          mode7;
  logic [15:0]   widx7;
  logic [SW-1:0] wval7;
  logic [AW-1:0] a00_7, a01_7, a10_7, a11_7;
  logic [F-1:0]  tc7, tr7;
  logic [31:0]   rb0, rb1;

  assign rb0 = 32'(r0_6) * 32'(cols_n);
  assign rb1 = 32'(r1_6) * 32'(cols_n);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      mode7 <= mode6;
      widx7 <= widx6;
      wval7 <= wval6;
      tc7   <= tc6;
      tr7   <= tr6;
      a00_7 <= AW'(rb0 + 32'(c0_6));
      a01_7 <= AW'(rb0 + 32'(c1_6));
      a10_7 <= AW'(rb1 + 32'(c0_6));
      a11_7 <= AW'(rb1 + 32'(c1_6));
    end
  end

  // ---------------- stage 8: grid memory ----------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] q00, q01, q10, q11;
  logic [F-1:0]  tc8, tr8;

  assign ram_we    = en[8] && v[7] && (mode7 == gbhl_pkg::MODE_WRITE)
                     && (32'(widx7) < 32'(GRID));
  assign ram_waddr = AW'(widx7);

  gbhl_ram #(.WIDTH(SW), .DEPTH(GRID)) u_ram00 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wval7),
    .re(en[8]), .raddr(a00_7), .rdata(q00));
  gbhl_ram #(.WIDTH(SW), .DEPTH(GRID)) u_ram01 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wval7),
    .re(en[8]), .raddr(a01_7), .rdata(q01));
  gbhl_ram #(.WIDTH(SW), .DEPTH(GRID)) u_ram10 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wval7),
    .re(en[8]), .raddr(a10_7), .rdata(q10));
  gbhl_ram #(.WIDTH(SW), .DEPTH(GRID)) u_ram11 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wval7),
    .re(en[8]), .raddr(a11_7), .rdata(q11));

  always_ff @(posedge clk) begin
    if (en[8]) begin
      tc8 <= tc7;
      tr8 <= tr7;
    end
  end

  // ---------------- stage 9: column differences ----------------
  logic signed [SW:0]   d0_9, d1_9;
  logic signed [SW-1:0] v00_9, v10_9;
  logic [F-1:0]         tc9, tr9;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      d0_9  <= $signed({q01[SW-1], q01}) - $signed({q00[SW-1], q00});
      d1_9  <= $signed({q11[SW-1], q11}) - $signed({q10[SW-1], q10});
      v00_9 <= $signed(q00);
      v10_9 <= $signed(q10);
      tc9   <= tc8;
      tr9   <= tr8;
    end
  end

  // ---------------- stage 10: column weight products ----------------
  logic signed [LW-1:0] m0_10, m1_10;
  logic signed [SW-1:0] v00_10, v10_10;
  logic [F-1:0]         tr10;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      m0_10  <= d0_9 * $signed({1'b0, tc9});
      m1_10  <= d1_9 * $signed({1'b0, tc9});
      v00_10 <= v00_9;
      v10_10 <= v10_9;
      tr10   <= tr9;
    end
  end

  // ---------------- stage 11: row endpoints ----------------
  logic signed [LW-1:0] lat0_11, lat1_11;
  logic [F-1:0]         tr11;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      lat0_11 <= (LW'(v00_10) <<< F) + m0_10;
      lat1_11 <= (LW'(v10_10) <<< F) + m1_10;
      tr11    <= tr10;
    end
  end

  // ---------------- stage 12: row difference ----------------
  logic signed [DW-1:0] dl12;
  logic signed [LW-1:0] lat0_12;
  logic [F-1:0]         tr12;

  always_ff @(posedge clk) begin
    if (en[12]) begin
      dl12    <= DW'(lat1_11) - DW'(lat0_11);
      lat0_12 <= lat0_11;
      tr12    <= tr11;
    end
  end

  // ---------------- stage 13: row weight product ----------------
  logic signed [MW-1:0] pm13;
  logic signed [LW-1:0] lat0_13;

  always_ff @(posedge clk) begin
    if (en[13]) begin
      pm13    <= dl12 * $signed({1'b0, tr12});
      lat0_13 <= lat0_12;
    end
  end

  // ---------------- stage 14: output register ----------------
  logic signed [MW-1:0] acc;

  assign acc = (MW'(lat0_13) <<< F) + pm13;

  always_ff @(posedge clk) begin
    if (en[14]) begin
      // bit select is a floor shift in two's complement
      height <= acc[OSH+31:OSH];
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          if (k == 8) begin
            // write beats retire at the memory stage
            v[k] <= v[k-1] && (mode7 == gbhl_pkg::MODE_QUERY);
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  // ---------------- assertions ----------------
  a_idx_in_grid: assert property (@(posedge clk) disable iff (rst)
    v[6] |-> (c0_6 <= cols_m1) && (c1_6 <= cols_m1) && (r0_6 <= rows_m1) && (r1_6 <= rows_m1))
    else $error("neighbour index outside grid");

  a_neighbour: assert property (@(posedge clk) disable iff (rst)
    v[6] |-> ((c1_6 == c0_6) || (c1_6 == c0_6 + CW'(1)))
          && ((r1_6 == r0_6) || (r1_6 == r0_6 + RW'(1))))
    else $error("neighbour not adjacent");

  a_clamp_frac: assert property (@(posedge clk) disable iff (rst)
    (v[5] && !cbl5) |-> (cpos5[F-1:0] == '0))
    else $error("clamped column has a fraction");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v[1] && v[NST]))
    else $error("input stalled with room in pipeline");

endmodule

`default_nettype wire
